// File: design/vfve_pkg.sv
// Shared types, constants and the corner table of the voxel face vertex emitter.
package vfve_pkg;

  localparam int CoordBits   = 24;
  localparam int HeightBits  = 8;
  localparam int ColorBits   = 8;
  localparam int GainBits    = 9;
  localparam int GainFrac    = 8;
  localparam int FaceCnt     = 6;
  localparam int VertPerFace = 6;
  localparam int FaceBits    = 3;
  localparam int VtxBits     = $clog2(VertPerFace);
  localparam int CfgIdxBits  = 2;
  localparam int FifoDepth   = 2;
  localparam int PtrBits     = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntBits     = $clog2(FifoDepth + 1);

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] REG_GAIN_TOP         = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_GAIN_BOTTOM      = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_GAIN_EAST_WEST   = 2'd2;
  localparam logic [CfgIdxBits-1:0] REG_GAIN_NORTH_SOUTH = 2'd3;

  localparam logic [GainBits-1:0] GAIN_TOP_RST         = 9'd256;
  localparam logic [GainBits-1:0] GAIN_BOTTOM_RST      = 9'd128;
  localparam logic [GainBits-1:0] GAIN_EAST_WEST_RST   = 9'd205;
  localparam logic [GainBits-1:0] GAIN_NORTH_SOUTH_RST = 9'd179;

  // Face codes, also the bit order of open_faces
  localparam logic [FaceBits-1:0] FACE_TOP    = 3'd0;
  localparam logic [FaceBits-1:0] FACE_BOTTOM = 3'd1;
  localparam logic [FaceBits-1:0] FACE_EAST   = 3'd2;
  localparam logic [FaceBits-1:0] FACE_WEST   = 3'd3;
  localparam logic [FaceBits-1:0] FACE_SOUTH  = 3'd4;
  localparam logic [FaceBits-1:0] FACE_NORTH  = 3'd5;

  // Corner offsets per face and vertex: bit0 dx, bit1 dy, bit2 dz
  localparam logic [2:0] CORNER_TAB [FaceCnt][VertPerFace] = '{
    '{3'd2, 3'd3, 3'd7, 3'd2, 3'd7, 3'd6},
    '{3'd0, 3'd5, 3'd1, 3'd0, 3'd4, 3'd5},
    '{3'd1, 3'd3, 3'd7, 3'd1, 3'd7, 3'd5},
    '{3'd0, 3'd6, 3'd2, 3'd0, 3'd4, 3'd6},
    '{3'd4, 3'd7, 3'd5, 3'd4, 3'd6, 3'd7},
    '{3'd0, 3'd1, 3'd3, 3'd0, 3'd3, 3'd2}
  };

  typedef struct packed {
    logic signed [CoordBits-1:0]  pos_x;
    logic        [HeightBits-1:0] pos_y;
    logic signed [CoordBits-1:0]  pos_z;
    logic                         solid;
    logic        [FaceCnt-1:0]    open_faces;
    logic        [ColorBits-1:0]  red_in;
    logic        [ColorBits-1:0]  green_in;
    logic        [ColorBits-1:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordBits-1:0]  vert_x;
    logic        [HeightBits:0]   vert_y;
    logic signed [CoordBits-1:0]  vert_z;
    logic        [ColorBits-1:0]  red_out;
    logic        [ColorBits-1:0]  green_out;
    logic        [ColorBits-1:0]  blue_out;
    logic        [FaceBits-1:0]   face_id;
    logic                         last_vertex;
  } out_item_t;

  // Queued voxel with at least one open face
  typedef struct packed {
    logic signed [CoordBits-1:0]  pos_x;
    logic        [HeightBits-1:0] pos_y;
    logic signed [CoordBits-1:0]  pos_z;
    logic        [FaceCnt-1:0]    open_faces;
    logic        [ColorBits-1:0]  red;
    logic        [ColorBits-1:0]  green;
    logic        [ColorBits-1:0]  blue;
  } job_t;

  typedef struct packed {
    logic [GainBits-1:0] top;
    logic [GainBits-1:0] bottom;
    logic [GainBits-1:0] east_west;
    logic [GainBits-1:0] north_south;
  } gains_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PICK,
    BK_EMIT
  } bk_state_t;

endpackage

// File: design/voxel_face_vertex_emitter.sv
// Top level of the voxel face vertex emitter: gain registers, front end, queue, sequencer.
//
//   channel  ports                          payload          direction
//   in       in_valid / in_ready            in_data (voxel)  into block
//   out      out_valid / out_ready          out_data (vertex) out of block
//   cfg      cfg_we, cfg_idx                cfg_data (gain)  into block
//
// In the sequencer a voxel with F open faces is first taken from the queue (BK_IDLE),
// then per face the gain multiply runs (BK_PICK) and six vertices are sent (BK_EMIT).
// Air and hidden voxels are dropped in the front end and use no sequencer time.
// Reset is synchronous, active low; it empties the queue and restores the default gains.
// A stalled output holds the sequencer; the front end and queue keep taking voxels
// until the queue fills.
module voxel_face_vertex_emitter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vfve_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vfve_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [vfve_pkg::CfgIdxBits-1:0]     cfg_idx,
  input  logic [vfve_pkg::GainBits-1:0]       cfg_data
);

  vfve_pkg::gains_t gains_r, gains_nxt;
  logic             push;
  vfve_pkg::job_t   push_data;
  logic             q_full;
  logic             q_valid;
  vfve_pkg::job_t   q_data;
  logic             pop;

  always_comb begin
    gains_nxt = gains_r;
    if (cfg_we) begin
      case (cfg_idx)
        vfve_pkg::REG_GAIN_TOP:         gains_nxt.top         = cfg_data;
        vfve_pkg::REG_GAIN_BOTTOM:      gains_nxt.bottom      = cfg_data;
        vfve_pkg::REG_GAIN_EAST_WEST:   gains_nxt.east_west   = cfg_data;
        vfve_pkg::REG_GAIN_NORTH_SOUTH: gains_nxt.north_south = cfg_data;
        default:                        gains_nxt             = gains_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.top         <= vfve_pkg::GAIN_TOP_RST;
      gains_r.bottom      <= vfve_pkg::GAIN_BOTTOM_RST;
      gains_r.east_west   <= vfve_pkg::GAIN_EAST_WEST_RST;
      gains_r.north_south <= vfve_pkg::GAIN_NORTH_SOUTH_RST;
    end else begin
      gains_r <= gains_nxt;
    end
  end

  vfve_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  vfve_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  vfve_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .gains     (gains_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: design/vfve_front.sv
// Front end: accepts voxels, drops air and hidden ones, stages the rest for the queue.
module vfve_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vfve_pkg::in_item_t in_data,
  output logic              push,
  output vfve_pkg::job_t    push_data,
  input  logic              q_full
);

  logic           fr_valid_r, fr_valid_nxt;
  vfve_pkg::job_t fr_job_r, fr_job_nxt;
  logic           in_fire;
  logic           keep;

  assign push     = fr_valid_r && !q_full;
  assign in_ready = !fr_valid_r || !q_full;
  assign in_fire  = in_valid && in_ready;
  assign keep     = in_data.solid && (in_data.open_faces != '0);
  assign push_data = fr_job_r;

  always_comb begin
    fr_valid_nxt = fr_valid_r && !push;
    fr_job_nxt   = fr_job_r;
    if (in_fire) begin
      // air and fully hidden voxels produce no vertices: drop them here
      fr_valid_nxt          = keep;
      fr_job_nxt.pos_x      = in_data.pos_x;
      fr_job_nxt.pos_y      = in_data.pos_y;
      fr_job_nxt.pos_z      = in_data.pos_z;
      fr_job_nxt.open_faces = in_data.open_faces;
      fr_job_nxt.red        = in_data.red_in;
      fr_job_nxt.green      = in_data.green_in;
      fr_job_nxt.blue       = in_data.blue_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_job_r <= fr_job_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    fr_valid_r |-> (fr_job_r.open_faces != '0))
    else $error("front staged a voxel with no open face");

  assert property (@(posedge clk) disable iff (!rst_n)
    (fr_valid_r && q_full) |=> (fr_valid_r && $stable(fr_job_r)))
    else $error("front lost a staged voxel while the queue was full");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !keep && !fr_valid_r) |=> !fr_valid_r)
    else $error("front staged a dropped voxel");

endmodule

// File: design/vfve_fifo.sv
// Short voxel queue between the front end and the vertex sequencer.
module vfve_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vfve_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output vfve_pkg::job_t q_data
);

  vfve_pkg::job_t                     mem_r [vfve_pkg::FifoDepth];
  logic [vfve_pkg::PtrBits-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [vfve_pkg::PtrBits-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [vfve_pkg::CntBits-1:0]       cnt_r, cnt_nxt;
  logic                               do_push, do_pop;

  assign full    = (cnt_r == vfve_pkg::CntBits'(vfve_pkg::FifoDepth));
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == vfve_pkg::PtrBits'(vfve_pkg::FifoDepth - 1))
                   ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == vfve_pkg::PtrBits'(vfve_pkg::FifoDepth - 1))
                   ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= vfve_pkg::CntBits'(vfve_pkg::FifoDepth))
    else $error("queue count beyond depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (rd_ptr_r == wr_ptr_r))
    else $error("queue pointers disagree on empty");

  assert property (@(posedge clk) disable iff (!rst_n)
    full |-> (rd_ptr_r == wr_ptr_r))
    else $error("queue pointers disagree on full");

endmodule

// File: design/vfve_back.sv
// Vertex sequencer: walks open faces, scales colour per face, emits six vertices each.
module vfve_back (
  input  logic                clk,
  input  logic                rst_n,
  input  vfve_pkg::gains_t    gains,
  input  logic                q_valid,
  input  vfve_pkg::job_t      q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output vfve_pkg::out_item_t out_data
);

  localparam int ProdBits = vfve_pkg::ColorBits + vfve_pkg::GainBits;

  vfve_pkg::bk_state_t                 state_r, state_nxt;
  vfve_pkg::job_t                      job_r, job_nxt;
  logic [vfve_pkg::FaceCnt-1:0]        faces_left_r, faces_left_nxt;
  logic [vfve_pkg::FaceBits-1:0]       face_r, face_nxt;
  logic [vfve_pkg::VtxBits-1:0]        vtx_r, vtx_nxt;
  logic [vfve_pkg::ColorBits-1:0]      red_r, red_nxt;
  logic [vfve_pkg::ColorBits-1:0]      green_r, green_nxt;
  logic [vfve_pkg::ColorBits-1:0]      blue_r, blue_nxt;
  logic                                out_valid_r, out_valid_nxt;
  vfve_pkg::out_item_t                 out_data_r, out_data_nxt;

  logic [vfve_pkg::FaceBits-1:0]       pick;
  logic [vfve_pkg::GainBits-1:0]       gain_sel;
  logic [2:0]                          corner;
  logic                                load;
  logic                                face_done;

  function automatic logic [vfve_pkg::ColorBits-1:0] scale_ch(
    input logic [vfve_pkg::ColorBits-1:0] ch,
    input logic [vfve_pkg::GainBits-1:0]  g
  );
    logic [ProdBits-1:0]                       prod;
    logic [ProdBits-vfve_pkg::GainFrac-1:0]    shr;
    prod = ProdBits'(ch) * ProdBits'(g);
    shr  = prod[ProdBits-1:vfve_pkg::GainFrac];
    // saturate when the gain pushes the channel past full scale
    if (shr > (ProdBits-vfve_pkg::GainFrac)'({vfve_pkg::ColorBits{1'b1}})) begin
      return {vfve_pkg::ColorBits{1'b1}};
    end
    return shr[vfve_pkg::ColorBits-1:0];
  endfunction

  // lowest open face first: top, bottom, east, west, south, north
  always_comb begin
    pick = '0;
    for (int i = vfve_pkg::FaceCnt - 1; i >= 0; i--) begin
      if (faces_left_r[i]) begin
        pick = vfve_pkg::FaceBits'(i);
      end
    end
  end

  always_comb begin
    case (pick)
      vfve_pkg::FACE_TOP:    gain_sel = gains.top;
      vfve_pkg::FACE_BOTTOM: gain_sel = gains.bottom;
      vfve_pkg::FACE_EAST,
      vfve_pkg::FACE_WEST:   gain_sel = gains.east_west;
      default:               gain_sel = gains.north_south;
    endcase
  end

  assign corner    = vfve_pkg::CORNER_TAB[face_r][vtx_r];
  assign load      = (state_r == vfve_pkg::BK_EMIT) && (!out_valid_r || out_ready);
  assign face_done = (vtx_r == vfve_pkg::VtxBits'(vfve_pkg::VertPerFace - 1));

  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    faces_left_nxt = faces_left_r;
    face_nxt       = face_r;
    vtx_nxt        = vtx_r;
    red_nxt        = red_r;
    green_nxt      = green_r;
    blue_nxt       = blue_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    pop            = 1'b0;
    case (state_r)
      vfve_pkg::BK_IDLE: begin
        if (q_valid) begin
          pop            = 1'b1;
          job_nxt        = q_data;
          faces_left_nxt = q_data.open_faces;
          state_nxt      = vfve_pkg::BK_PICK;
        end
      end
      vfve_pkg::BK_PICK: begin
        face_nxt       = pick;
        faces_left_nxt = faces_left_r & ~(vfve_pkg::FaceCnt'(1) << pick);
        red_nxt        = scale_ch(job_r.red, gain_sel);
        green_nxt      = scale_ch(job_r.green, gain_sel);
        blue_nxt       = scale_ch(job_r.blue, gain_sel);
        vtx_nxt        = '0;
        state_nxt      = vfve_pkg::BK_EMIT;
      end
      vfve_pkg::BK_EMIT: begin
        if (load) begin
          out_valid_nxt            = 1'b1;
          // x and z wrap at the top of their range like a plain adder; y has a spare bit
          out_data_nxt.vert_x      = job_r.pos_x +
                                     {{(vfve_pkg::CoordBits-1){1'b0}}, corner[0]};
          out_data_nxt.vert_y      = {1'b0, job_r.pos_y} +
                                     {{vfve_pkg::HeightBits{1'b0}}, corner[1]};
          out_data_nxt.vert_z      = job_r.pos_z +
                                     {{(vfve_pkg::CoordBits-1){1'b0}}, corner[2]};
          out_data_nxt.red_out     = red_r;
          out_data_nxt.green_out   = green_r;
          out_data_nxt.blue_out    = blue_r;
          out_data_nxt.face_id     = face_r;
          out_data_nxt.last_vertex = face_done && (faces_left_r == '0);
          vtx_nxt                  = vtx_r + 1'b1;
          if (face_done) begin
            state_nxt = (faces_left_r == '0) ? vfve_pkg::BK_IDLE : vfve_pkg::BK_PICK;
          end
        end
      end
      default: begin
        state_nxt = vfve_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vfve_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r        <= job_nxt;
    faces_left_r <= faces_left_nxt;
    face_r       <= face_nxt;
    vtx_r        <= vtx_nxt;
    red_r        <= red_nxt;
    green_r      <= green_nxt;
    blue_r       <= blue_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (q_data.open_faces != '0))
    else $error("queued voxel has no open face");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vfve_pkg::BK_PICK) |-> (faces_left_r != '0))
    else $error("face pick with no face left");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vfve_pkg::BK_EMIT) |->
      (vtx_r < vfve_pkg::VtxBits'(vfve_pkg::VertPerFace)))
    else $error("vertex counter past end of face");

  assert property (@(posedge clk) disable iff (!rst_n)
    (load && out_data_nxt.last_vertex) |=> (state_r == vfve_pkg::BK_IDLE))
    else $error("last vertex sent but sequencer still busy");

endmodule
